FILE: rtl/khm_pkg.sv
// Package for the key hold counter repeat mapper: field widths, request types, op codes.
package khm_pkg;

    localparam int KEY_COUNT_DEF     = 512;
    localparam int VIRTUAL_CODES_DEF = 32;
    localparam int MAP_ENTRIES_DEF   = 64;
    localparam int COUNT_WIDTH_DEF   = 16;
    localparam int PERIOD_W          = 15;

    typedef enum logic [2:0] {
        OP_FRAME_BEGIN = 3'd0,
        OP_KEY_DOWN    = 3'd1,
        OP_KEY_UP      = 3'd2,
        OP_FRAME_END   = 3'd3,
        OP_MAP_WRITE   = 3'd4,
        OP_MAP_CLEAR   = 3'd5
    } t_op;

    typedef struct packed {
        logic [2:0]          op;
        logic [8:0]          key_code;
        logic [4:0]          vcode;
        logic signed [15:0]  start_frame;
        logic signed [15:0]  end_frame;
        logic [PERIOD_W-1:0] repeat_interval;
    } t_in;

    typedef struct packed {
        logic [31:0] active_mask;
        logic        table_full;
    } t_out;

    typedef struct packed {
        logic [8:0]          key_code;
        logic [4:0]          vcode;
        logic signed [15:0]  start_frame;
        logic signed [15:0]  end_frame;
        logic [PERIOD_W-1:0] repeat_interval;
    } t_map;

    typedef struct packed {
        logic load_req;
        logic clr_wr;
        logic idx_clr;
        logic idx_inc;
        logic swp_rd;
        logic swp_wr;
        logic key_rd;
        logic key_wr;
        logic map_wr;
        logic map_rd;
        logic cnt_map_rd;
        logic midx_clr;
        logic midx_inc;
        logic mask_clr;
        logic eval_chk;
        logic mod_start;
        logic mod_chk;
        logic mcnt_clr;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic idx_last;
        logic map_more;
        logic mcnt_zero;
        logic need_mod;
        logic mod_busy;
        logic mod_done;
    } t_sts;

endpackage

FILE: rtl/khm_mod.sv
// Bit-serial remainder unit: one dividend bit per cycle.
module khm_mod #(
    parameter int DW = 17
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [DW-1:0]                i_num,
    input  logic [khm_pkg::PERIOD_W-1:0] i_den,
    output logic                         o_busy,
    output logic                         o_done,
    output logic                         o_rem_zero
);
    import khm_pkg::*;

    localparam int CNTW = $clog2(DW + 1);

    logic [DW-1:0]       r_num;
    logic [PERIOD_W-1:0] r_rem;
    logic [PERIOD_W-1:0] r_den;
    logic [CNTW-1:0]     r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [PERIOD_W:0]   n_trial;
    logic [PERIOD_W-1:0] n_rem;

    always_comb begin
        n_trial = {r_rem, r_num[DW-1]};
        if (n_trial >= {1'b0, r_den}) begin
            n_rem = PERIOD_W'(n_trial - {1'b0, r_den});
        end else begin
            n_rem = PERIOD_W'(n_trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DW-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_rem_zero = (r_rem == '0);

endmodule

FILE: rtl/khm_dp.sv
// Datapath: counter memory, mapping memory, sweep and mapping indexes, mask and response.
module khm_dp #(
    parameter int KEY_COUNT     = khm_pkg::KEY_COUNT_DEF,
    parameter int VIRTUAL_CODES = khm_pkg::VIRTUAL_CODES_DEF,
    parameter int MAP_ENTRIES   = khm_pkg::MAP_ENTRIES_DEF,
    parameter int COUNT_WIDTH   = khm_pkg::COUNT_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  khm_pkg::t_in  i_req,
    input  khm_pkg::t_cmd i_cmd,
    output khm_pkg::t_sts o_sts,
    output khm_pkg::t_out o_rsp
);
    import khm_pkg::*;

    localparam int KW  = $clog2(KEY_COUNT);
    localparam int MIW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
    localparam int MCW = $clog2(MAP_ENTRIES + 1);
    localparam int XW  = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 1;
    localparam logic signed [COUNT_WIDTH-1:0] CMIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
    localparam logic signed [COUNT_WIDTH-1:0] CMAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};

    logic signed [COUNT_WIDTH-1:0] cnt_mem [KEY_COUNT];
    t_map                          map_mem [MAP_ENTRIES];

    t_in                           r_req;
    t_map                          r_map;
    logic signed [COUNT_WIDTH-1:0] r_cnt_rd;
    logic [KW-1:0]                 r_idx;
    logic [MIW-1:0]                r_midx;
    logic [MCW-1:0]                r_mcnt;
    logic [31:0]                   r_mask;
    logic                          r_full;
    t_out                          r_rsp;

    logic                          key_ok;
    logic [KW-1:0]                 key_idx;
    logic [KW-1:0]                 map_idx;
    logic                          map_ok;
    logic                          win_ok;
    logic signed [XW-1:0]          c_x;
    logic signed [XW-1:0]          first_x;
    logic signed [XW-1:0]          last_x;
    logic [XW-1:0]                 diff;
    logic                          cnt_we;
    logic [KW-1:0]                 cnt_wa;
    logic signed [COUNT_WIDTH-1:0] cnt_wd;
    logic                          cnt_re;
    logic [KW-1:0]                 cnt_ra;
    logic                          tbl_full;
    logic                          mod_busy;
    logic                          mod_done;
    logic                          mod_rz;

    assign key_ok   = (32'(r_req.key_code) < KEY_COUNT);
    assign key_idx  = KW'(r_req.key_code);
    assign map_idx  = KW'(r_map.key_code);
    assign map_ok   = (32'(r_map.key_code) < KEY_COUNT) &&
                      (32'(r_map.vcode) < VIRTUAL_CODES);
    assign c_x      = XW'(r_cnt_rd);
    assign first_x  = XW'(r_map.start_frame);
    assign last_x   = XW'(r_map.end_frame);
    assign win_ok   = map_ok && (c_x >= first_x) && (c_x <= last_x);
    assign diff     = XW'(c_x - first_x);
    assign tbl_full = (r_mcnt == MCW'(MAP_ENTRIES));

    always_comb begin
        cnt_we = 1'b0;
        cnt_wa = r_idx;
        cnt_wd = '1;
        if (i_cmd.clr_wr) begin
            cnt_we = 1'b1;
        end else if (i_cmd.swp_wr) begin
            cnt_we = 1'b1;
            cnt_wd = r_cnt_rd;
            if (r_req.op == OP_FRAME_BEGIN) begin
                if (r_cnt_rd < 0 && r_cnt_rd != CMIN) begin
                    cnt_wd = r_cnt_rd - 1'b1;
                end
            end else if (r_cnt_rd >= 0 && r_cnt_rd != CMAX) begin
                cnt_wd = r_cnt_rd + 1'b1;
            end
        end else if (i_cmd.key_wr) begin
            cnt_we = key_ok;
            cnt_wa = key_idx;
            if (r_req.op == OP_KEY_DOWN) begin
                cnt_wd = (r_cnt_rd < 0) ? '0 : r_cnt_rd;
            end
        end
    end

    always_comb begin
        cnt_re = i_cmd.swp_rd | i_cmd.key_rd | i_cmd.cnt_map_rd;
        if (i_cmd.key_rd) begin
            cnt_ra = key_idx;
        end else if (i_cmd.cnt_map_rd) begin
            cnt_ra = map_idx;
        end else begin
            cnt_ra = r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        if (cnt_re) begin
            r_cnt_rd <= cnt_mem[cnt_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.map_wr && !tbl_full) begin
            map_mem[MIW'(r_mcnt)] <= '{key_code: r_req.key_code,
                                       vcode: r_req.vcode,
                                       start_frame: r_req.start_frame,
                                       end_frame: r_req.end_frame,
                                       repeat_interval: r_req.repeat_interval};
        end
        if (i_cmd.map_rd) begin
            r_map <= map_mem[r_midx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_midx <= '0;
            r_mcnt <= '0;
            r_full <= 1'b0;
        end else begin
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.midx_clr) begin
                r_midx <= '0;
            end else if (i_cmd.midx_inc) begin
                r_midx <= r_midx + 1'b1;
            end
            if (i_cmd.mcnt_clr) begin
                r_mcnt <= '0;
            end else if (i_cmd.map_wr) begin
                r_full <= tbl_full;
                if (!tbl_full) begin
                    r_mcnt <= r_mcnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_req;
        end
        if (i_cmd.mask_clr) begin
            r_mask <= '0;
        end else if ((i_cmd.eval_chk && win_ok && r_map.repeat_interval == '0) ||
                     (i_cmd.mod_chk && mod_rz)) begin
            r_mask[r_map.vcode] <= 1'b1;
        end
        if (i_cmd.out_load) begin
            r_rsp.active_mask <= (r_req.op == OP_FRAME_END) ? r_mask : '0;
            r_rsp.table_full  <= (r_req.op == OP_MAP_WRITE) ? r_full : 1'b0;
        end
    end

    khm_mod #(.DW(XW)) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.mod_start),
        .i_num      (diff),
        .i_den      (r_map.repeat_interval),
        .o_busy     (mod_busy),
        .o_done     (mod_done),
        .o_rem_zero (mod_rz)
    );

    assign o_sts.idx_last  = (r_idx == KW'(KEY_COUNT - 1));
    assign o_sts.map_more  = ((MCW+1)'(r_midx) + 1'b1) < (MCW+1)'(r_mcnt);
    assign o_sts.mcnt_zero = (r_mcnt == '0);
    assign o_sts.need_mod  = win_ok && (r_map.repeat_interval != '0);
    assign o_sts.mod_busy  = mod_busy;
    assign o_sts.mod_done  = mod_done;
    assign o_rsp           = r_rsp;

endmodule

FILE: rtl/khm_ctrl.sv
// Controller: sequences clearing, counter sweeps, key updates, mapping writes and evaluation.
module khm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [2:0]    i_op,
    input  khm_pkg::t_sts i_sts,
    output khm_pkg::t_cmd o_cmd,
    output logic          o_valid,
    input  logic          i_ready
);
    import khm_pkg::*;

    typedef enum logic [11:0] {
        S_CLEAR    = 12'b000000000001,
        S_IDLE     = 12'b000000000010,
        S_SWP_RD   = 12'b000000000100,
        S_SWP_WR   = 12'b000000001000,
        S_KEY_RD   = 12'b000000010000,
        S_KEY_WR   = 12'b000000100000,
        S_MAP_WR   = 12'b000001000000,
        S_MAP_RD   = 12'b000010000000,
        S_CNT_RD   = 12'b000100000000,
        S_EVAL     = 12'b001000000000,
        S_MOD_WAIT = 12'b010000000000,
        S_DONE     = 12'b100000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   accept;
    // sweep kind is latched with the request
    logic   r_is_end;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign o_valid = r_valid;

    always_comb begin
        n_state = r_state;
        n_valid = r_valid;
        o_cmd   = '0;
        if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr  = 1'b1;
                o_cmd.idx_inc = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load_req = 1'b1;
                    o_cmd.idx_clr  = 1'b1;
                    o_cmd.midx_clr = 1'b1;
                    o_cmd.mask_clr = 1'b1;
                    case (i_op)
                        OP_FRAME_BEGIN, OP_FRAME_END: n_state = S_SWP_RD;
                        OP_KEY_DOWN, OP_KEY_UP:       n_state = S_KEY_RD;
                        OP_MAP_WRITE:                 n_state = S_MAP_WR;
                        OP_MAP_CLEAR:                 o_cmd.mcnt_clr = 1'b1;
                        default:                      n_state = S_IDLE;
                    endcase
                end
            end
            S_SWP_RD: begin
                o_cmd.swp_rd = 1'b1;
                n_state      = S_SWP_WR;
            end
            S_SWP_WR: begin
                o_cmd.swp_wr  = 1'b1;
                o_cmd.idx_inc = 1'b1;
                if (!i_sts.idx_last) begin
                    n_state = S_SWP_RD;
                end else if (r_is_end) begin
                    n_state = i_sts.mcnt_zero ? S_DONE : S_MAP_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_KEY_RD: begin
                o_cmd.key_rd = 1'b1;
                n_state      = S_KEY_WR;
            end
            S_KEY_WR: begin
                o_cmd.key_wr = 1'b1;
                n_state      = S_IDLE;
            end
            S_MAP_WR: begin
                o_cmd.map_wr = 1'b1;
                n_state      = S_DONE;
            end
            S_MAP_RD: begin
                o_cmd.map_rd = 1'b1;
                n_state      = S_CNT_RD;
            end
            S_CNT_RD: begin
                o_cmd.cnt_map_rd = 1'b1;
                n_state          = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval_chk = 1'b1;
                if (i_sts.need_mod) begin
                    o_cmd.mod_start = 1'b1;
                    n_state         = S_MOD_WAIT;
                end else if (i_sts.map_more) begin
                    o_cmd.midx_inc = 1'b1;
                    n_state        = S_MAP_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MOD_WAIT: begin
                if (i_sts.mod_done) begin
                    o_cmd.mod_chk = 1'b1;
                    if (i_sts.map_more) begin
                        o_cmd.midx_inc = 1'b1;
                        n_state        = S_MAP_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_valid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_valid        = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_valid  <= 1'b0;
            r_is_end <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (accept) begin
                r_is_end <= (i_op == OP_FRAME_END);
            end
        end
    end

endmodule

FILE: rtl/key_hold_counter_repeat_mapper.sv
// Key hold counter repeat mapper top level: controller, datapath and checks.
// Frame begin/end: each key counter is read, then written back through the counter memory port.
// Frame end then reads and evaluates each mapping and its key counter, waiting on the bit-serial
// remainder unit for a windowed mapping with an interval; key events read and write one counter.
// One request at a time; after reset every counter is cleared to -1 before any is taken.
// Reset is synchronous active low; the mapping table is empty after reset.
module key_hold_counter_repeat_mapper #(
    parameter int KEY_COUNT     = khm_pkg::KEY_COUNT_DEF,
    parameter int VIRTUAL_CODES = khm_pkg::VIRTUAL_CODES_DEF,
    parameter int MAP_ENTRIES   = khm_pkg::MAP_ENTRIES_DEF,
    parameter int COUNT_WIDTH   = khm_pkg::COUNT_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  khm_pkg::t_in  i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output khm_pkg::t_out o_rsp
);
    import khm_pkg::*;

    t_cmd cmd;
    t_sts sts;

    khm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_op    (i_req.op),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_valid (o_valid),
        .i_ready (i_ready)
    );

    khm_dp #(
        .KEY_COUNT     (KEY_COUNT),
        .VIRTUAL_CODES (VIRTUAL_CODES),
        .MAP_ENTRIES   (MAP_ENTRIES),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_rsp   (o_rsp)
    );

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_valid || i_ready))
        else $error("response overwritten while pending");

    a_mod_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.mod_start |-> !sts.mod_busy)
        else $error("remainder unit restarted while busy");

    a_no_req_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clr_wr |-> !o_ready)
        else $error("request taken during counter clear");

endmodule

FILE: verif/tb_top.sv
// Testbench for the key hold counter repeat mapper: directed table plus random requests.
`timescale 1ns / 1ps

module tb_top;
    import khm_pkg::*;

    localparam int NKEYS      = 512;
    localparam int NMAP       = 64;
    localparam int CMAX       = 32767;
    localparam int CMIN       = -32768;
    localparam int CYCLE_CAP  = 6000000;
    localparam int RAND_ITEMS = 485;
    localparam int KEY_POOL   = 8;

    typedef struct {
        t_in  req;
        bit   has_exp;
        t_out exp;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_in  i_req;
    logic o_valid;
    logic i_ready;
    t_out o_rsp;

    key_hold_counter_repeat_mapper dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (o_rsp)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    int   hold_cnt [NKEYS];
    t_map map_tab [NMAP];
    int   map_used;
    t_out pending_rsp [$];

    int   errors;
    int   mismatches;
    int   cycles;
    int   n_rsp;
    int   n_fired;
    int   n_full;
    bit   quiet_phase;
    bit   hold_off;
    bit   stim_done;

    task automatic model_step(input t_in r);
        t_out o;
        int c;
        int s;
        int e;
        logic [31:0] m;
        o = '0;
        case (t_op'(r.op))
            OP_FRAME_BEGIN: begin
                for (int k = 0; k < NKEYS; k++)
                    if (hold_cnt[k] < 0 && hold_cnt[k] > CMIN) hold_cnt[k]--;
            end
            OP_KEY_DOWN: if (hold_cnt[r.key_code] < 0) hold_cnt[r.key_code] = 0;
            OP_KEY_UP: hold_cnt[r.key_code] = -1;
            OP_FRAME_END: begin
                for (int k = 0; k < NKEYS; k++)
                    if (hold_cnt[k] >= 0 && hold_cnt[k] < CMAX) hold_cnt[k]++;
                m = '0;
                for (int i = 0; i < map_used; i++) begin
                    c = hold_cnt[map_tab[i].key_code];
                    s = map_tab[i].start_frame;
                    e = map_tab[i].end_frame;
                    if (c >= s && c <= e &&
                        (map_tab[i].repeat_interval == 0 ||
                         ((c - s) % int'(map_tab[i].repeat_interval)) == 0))
                        m[map_tab[i].vcode] = 1'b1;
                end
                o.active_mask = m;
                pending_rsp.push_back(o);
            end
            OP_MAP_WRITE: begin
                if (map_used < NMAP) begin
                    map_tab[map_used] = {r.key_code, r.vcode, r.start_frame,
                                         r.end_frame, r.repeat_interval};
                    map_used++;
                end else begin
                    o.table_full = 1'b1;
                end
                pending_rsp.push_back(o);
            end
            OP_MAP_CLEAR: map_used = 0;
            default: ;
        endcase
    endtask

    function automatic t_in mk(input logic [2:0] op, input int key = 0, input int vc = 0,
                               input int st = 0, input int en = 0, input int iv = 0);
        t_in r;
        r.op              = op;
        r.key_code        = key[8:0];
        r.vcode           = vc[4:0];
        r.start_frame     = st[15:0];
        r.end_frame       = en[15:0];
        r.repeat_interval = iv[14:0];
        return r;
    endfunction

    function automatic t_row row(input t_in r);
        t_row w;
        w.req     = r;
        w.has_exp = 1'b0;
        w.exp     = '0;
        return w;
    endfunction

    function automatic t_row row_exp(input t_in r, input logic [31:0] mask,
                                     input logic full);
        t_row w;
        w.req     = r;
        w.has_exp = 1'b1;
        w.exp     = {mask, full};
        return w;
    endfunction

    // sender: drive at falling edge, hold until accepted
    task automatic send_req(input t_in r);
        int gap;
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        model_step(r);
        @(negedge i_clk);
    endtask

    // directed rows; typed expectations where they are obvious, the rest predicted
    t_row dir_rows [$];

    task automatic build_directed();
        dir_rows.push_back(row_exp(mk(OP_FRAME_END), 32'h0, 1'b0));
        dir_rows.push_back(row_exp(mk(OP_MAP_WRITE, 0, 0, 1, 3, 0), 32'h0, 1'b0));
        dir_rows.push_back(row_exp(mk(OP_MAP_WRITE, 511, 31, -32768, 32767, 32767),
                                   32'h0, 1'b0));
        dir_rows.push_back(row_exp(mk(OP_MAP_WRITE, 5, 7, 5, 2, 0), 32'h0, 1'b0));
        dir_rows.push_back(row_exp(mk(OP_MAP_WRITE, 1, 3, -3, -1, 2), 32'h0, 1'b0));
        dir_rows.push_back(row_exp(mk(OP_MAP_WRITE, 2, 4, 0, 32767, 3), 32'h0, 1'b0));
        dir_rows.push_back(row(mk(OP_KEY_DOWN, 0)));
        dir_rows.push_back(row(mk(OP_KEY_DOWN, 511)));
        dir_rows.push_back(row(mk(OP_KEY_DOWN, 2)));
        dir_rows.push_back(row(mk(OP_FRAME_BEGIN)));
        dir_rows.push_back(row(mk(OP_FRAME_END)));
        dir_rows.push_back(row(mk(OP_KEY_DOWN, 0)));
        dir_rows.push_back(row(mk(OP_FRAME_END)));
        dir_rows.push_back(row(mk(OP_FRAME_BEGIN)));
        dir_rows.push_back(row(mk(OP_FRAME_END)));
        dir_rows.push_back(row(mk(OP_KEY_UP, 0)));
        dir_rows.push_back(row(mk(OP_FRAME_BEGIN)));
        dir_rows.push_back(row(mk(OP_FRAME_END)));
        dir_rows.push_back(row(mk(3'd6, 511, 31, -1, -1, 32767)));
        dir_rows.push_back(row(mk(3'd7, 0, 0, 0, 0, 0)));
        dir_rows.push_back(row(mk(OP_MAP_CLEAR)));
        dir_rows.push_back(row_exp(mk(OP_FRAME_END), 32'h0, 1'b0));
    endtask

    function automatic t_in rand_req();
        t_in r;
        int  p;
        r = t_in'({$urandom, $urandom});
        p = $urandom_range(0, 99);
        r.key_code = ($urandom_range(0, 9) == 0) ? 9'($urandom) : 9'($urandom_range(0, KEY_POOL-1));
        if (p < 12) r.op = OP_FRAME_BEGIN;
        else if (p < 30) r.op = OP_KEY_DOWN;
        else if (p < 40) r.op = OP_KEY_UP;
        else if (p < 70) r.op = OP_FRAME_END;
        else if (p < 92) begin
            r.op = OP_MAP_WRITE;
            if ($urandom_range(0, 3) != 0) begin
                r.start_frame     = 16'($signed($urandom_range(0, 12)) - 6);
                r.end_frame       = 16'($signed($urandom_range(0, 40)) - 4);
                r.repeat_interval = 15'($urandom_range(0, 4));
            end
        end else if (p < 96) r.op = OP_MAP_CLEAR;
        else r.op = 3'($urandom_range(6, 7));
        return r;
    endfunction

    task automatic flood_table();
        for (int i = 0; i < NMAP + 3; i++) begin
            send_req(mk(OP_MAP_WRITE, i % KEY_POOL, i % 32, 0, 100, i % 5));
            pending_rsp[$] = {32'h0, (i >= NMAP)};
        end
        send_req(mk(OP_KEY_DOWN, 1));
        repeat (4) send_req(mk(OP_FRAME_END));
    endtask

    // receiver: random stalls, one long hold-off
    initial begin
        int gap;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_ready <= 1'b0;
                repeat (3000) @(negedge i_clk);
                hold_off = 1'b0;
            end
            if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                gap = $urandom_range(1, 15);
                repeat (gap) @(negedge i_clk);
            end
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_out x;
        if (i_rst_n && o_valid && i_ready) begin
            n_rsp++;
            if (pending_rsp.size() == 0) begin
                errors++;
                if (mismatches < 10) $display("unexpected response %h", o_rsp);
                mismatches++;
            end else begin
                x = pending_rsp.pop_front();
                if (o_rsp.active_mask != 0) n_fired++;
                if (o_rsp.table_full) n_full++;
                if (o_rsp !== x) begin
                    errors++;
                    if (mismatches < 10)
                        $display("mismatch: mask exp %h got %h, full exp %b got %b",
                                 x.active_mask, o_rsp.active_mask, x.table_full,
                                 o_rsp.table_full);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        errors = 0; mismatches = 0; cycles = 0; n_rsp = 0; n_fired = 0; n_full = 0;
        quiet_phase = 0; hold_off = 0; stim_done = 0;
        i_valid = 1'b0;
        i_req   = '0;
        i_rst_n = 1'b0;
        for (int k = 0; k < NKEYS; k++) hold_cnt[k] = -1;
        map_used = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        build_directed();
        foreach (dir_rows[i]) begin
            send_req(dir_rows[i].req);
            if (dir_rows[i].has_exp) pending_rsp[$] = dir_rows[i].exp;
        end
        flood_table();
        send_req(mk(OP_MAP_CLEAR));

        hold_off = 1'b1;
        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i == RAND_ITEMS - 80) quiet_phase = 1'b1;
            send_req(rand_req());
        end
        i_valid <= 1'b0;

        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (3000) @(posedge i_clk);

        $display("Covered directed extremes, table overflow, saturation-free windows and %0d",
                 n_rsp);
        $display("responses (%0d with active codes, %0d table-full refusals)", n_fired, n_full);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Verification failed");
        end
        $finish;
    end
endmodule
